// File: rtl/lzwmc_pkg.sv
// ----------------------------------------------------------------------------
// lzwmc_pkg
// shared types and constants of the lzw mini-cache compressor
// ----------------------------------------------------------------------------
package lzwmc_pkg;

   localparam int DICT_AW   = 10;            // dictionary address bits
   localparam int CACHE_IW  = 5;             // cache index bits (32 entries)
   localparam int CACHE_N   = 1 << CACHE_IW;
   localparam int ROOTS     = 256;
   localparam int ACC_W     = 19;            // 7 pending + 11 code bits + 1
   localparam int CNT_W     = 5;

   localparam logic [2:0]         CACHE_BITS_RST = 3'd3;
   localparam logic [2:0]         CACHE_BITS_MAX = 3'(CACHE_IW);
   localparam logic [DICT_AW:0]   FIRST_FREE     = (DICT_AW + 1)'(ROOTS);
   localparam logic [3:0]         WIDTH_RST      = 4'd9;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR,
      ST_CHILD_RD,
      ST_CHILD_CHK,
      ST_WALK_CHK,
      ST_ADD,
      ST_PUT,
      ST_END_CODE,
      ST_END_PUT,
      ST_PAD
   } state_type;

   typedef struct packed {
      logic latch_in;
      logic start_blk;
      logic link_child;
      logic walk_first;
      logic walk_next;
      logic take_match;
      logic link_sib;
      logic add_entry;
      logic send_end;
      logic emit_hdr;
      logic emit_acc;
      logic emit_last;
      logic emit_pad;
   } cmd_type;

   typedef struct packed {
      logic blk_open;
      logic blk_end;
      logic first_zero;
      logic match;
      logic sib_zero;
      logic cnt_ge8;
      logic cnt_zero;
      logic out_free;
   } sts_type;

endpackage

// File: rtl/lzwmc_ctrl.sv
// ----------------------------------------------------------------------------
// lzwmc_ctrl
// sequencer: trie walk, dictionary update and bit output per byte
// ----------------------------------------------------------------------------
module lzwmc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  lzwmc_pkg::sts_type sts,
   output lzwmc_pkg::cmd_type cmd
);

   lzwmc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzwmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == lzwmc_pkg::ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzwmc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.blk_open ? lzwmc_pkg::ST_CHILD_RD : lzwmc_pkg::ST_HDR;
            end
         end
         lzwmc_pkg::ST_HDR: begin
            if (sts.out_free) begin
               state_in = sts.blk_end ? lzwmc_pkg::ST_END_CODE : lzwmc_pkg::ST_IDLE;
            end
         end
         lzwmc_pkg::ST_CHILD_RD: state_in = lzwmc_pkg::ST_CHILD_CHK;
         lzwmc_pkg::ST_CHILD_CHK: begin
            state_in = sts.first_zero ? lzwmc_pkg::ST_ADD : lzwmc_pkg::ST_WALK_CHK;
         end
         lzwmc_pkg::ST_WALK_CHK: begin
            if (sts.match) begin
               state_in = sts.blk_end ? lzwmc_pkg::ST_END_CODE : lzwmc_pkg::ST_IDLE;
            end else if (sts.sib_zero) begin
               state_in = lzwmc_pkg::ST_ADD;
            end
         end
         lzwmc_pkg::ST_ADD: state_in = lzwmc_pkg::ST_PUT;
         lzwmc_pkg::ST_PUT: begin
            if (!sts.cnt_ge8) begin
               state_in = sts.blk_end ? lzwmc_pkg::ST_END_CODE : lzwmc_pkg::ST_IDLE;
            end
         end
         lzwmc_pkg::ST_END_CODE: state_in = lzwmc_pkg::ST_END_PUT;
         lzwmc_pkg::ST_END_PUT: begin
            if (!sts.cnt_ge8) begin
               state_in = sts.cnt_zero ? lzwmc_pkg::ST_IDLE : lzwmc_pkg::ST_PAD;
            end
         end
         lzwmc_pkg::ST_PAD: begin
            if (sts.out_free) begin
               state_in = lzwmc_pkg::ST_IDLE;
            end
         end
         default: state_in = lzwmc_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         lzwmc_pkg::ST_IDLE: cmd.latch_in = req_tvalid;
         lzwmc_pkg::ST_HDR: begin
            cmd.start_blk = sts.out_free;
            cmd.emit_hdr  = sts.out_free;
         end
         lzwmc_pkg::ST_CHILD_RD: cmd = '0;
         lzwmc_pkg::ST_CHILD_CHK: begin
            cmd.link_child = sts.first_zero;
            cmd.walk_first = !sts.first_zero;
         end
         lzwmc_pkg::ST_WALK_CHK: begin
            cmd.take_match = sts.match;
            cmd.walk_next  = !sts.match && !sts.sib_zero;
            cmd.link_sib   = !sts.match && sts.sib_zero;
         end
         lzwmc_pkg::ST_ADD: cmd.add_entry = 1'b1;
         lzwmc_pkg::ST_PUT: cmd.emit_acc = sts.cnt_ge8 && sts.out_free;
         lzwmc_pkg::ST_END_CODE: cmd.send_end = 1'b1;
         lzwmc_pkg::ST_END_PUT: begin
            cmd.emit_acc  = sts.cnt_ge8 && sts.out_free;
            cmd.emit_last = sts.cnt_ge8 && sts.out_free;
         end
         lzwmc_pkg::ST_PAD: cmd.emit_pad = sts.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// File: rtl/lzwmc_dpath.sv
// ----------------------------------------------------------------------------
// lzwmc_dpath
// trie memories, code cache, bit accumulator and output register
// ----------------------------------------------------------------------------
module lzwmc_dpath (
   input  logic               clock,
   input  logic               reset,
   input  lzwmc_pkg::cmd_type cmd,
   output lzwmc_pkg::sts_type sts,
   input  logic [7:0]         req_byte,
   input  logic               req_last,
   input  logic               csr_valid,
   input  logic [2:0]         csr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_byte,
   output logic               rsp_last
);

   localparam int AW = lzwmc_pkg::DICT_AW;
   localparam int IW = lzwmc_pkg::CACHE_IW;
   localparam int DEPTH = 1 << AW;

   // trie memories
   logic [7:0]    node_char_mem    [DEPTH];
   logic [AW-1:0] node_child_mem   [DEPTH];
   logic [AW-1:0] node_sibling_mem [DEPTH];
   logic [7:0]    char_q;
   logic [AW-1:0] child_q, sib_q;

   logic [2:0]    csr_ff;
   logic [2:0]    blk_bits_ff;
   logic [7:0]    byte_ff;
   logic          end_ff;
   logic          inside_ff;
   logic [AW:0]   free_ff;
   logic [3:0]    width_ff;
   logic [AW-1:0] prefix_ff;
   logic [AW-1:0] nd_ff;
   logic [lzwmc_pkg::ACC_W-1:0] acc_ff;
   logic [lzwmc_pkg::CNT_W-1:0] cnt_ff;
   logic [lzwmc_pkg::ROOTS-1:0] root_vld_ff;
   logic [AW-1:0] cache_ff [lzwmc_pkg::CACHE_N];
   logic [lzwmc_pkg::CACHE_N-1:0] cache_vld_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;

   logic          full;
   logic [AW-1:0] first;
   logic [AW-1:0] rd_addr;
   logic [7:0]    nd_char;
   logic [2:0]    eff_bits;
   logic [IW-1:0] mask, idx, fidx;
   logic [AW-1:0] cache_entry;
   logic          hit, send, fresh;
   logic [10:0]   send_val;
   logic [3:0]    send_bits;
   logic [AW:0]   grown;
   logic          out_free;

   assign full     = free_ff[AW];
   assign first    = (prefix_ff[AW-1:8] == '0 && !root_vld_ff[prefix_ff[7:0]])
                     ? '0 : child_q;
   assign rd_addr  = cmd.walk_first ? first : (cmd.walk_next ? sib_q : prefix_ff);
   assign nd_char  = (nd_ff[AW-1:8] == '0) ? nd_ff[7:0] : char_q;
   assign eff_bits = (csr_ff > lzwmc_pkg::CACHE_BITS_MAX) ? lzwmc_pkg::CACHE_BITS_MAX
                                                          : csr_ff;
   assign mask     = IW'((6'd1 << blk_bits_ff) - 6'd1);
   assign idx      = prefix_ff[IW-1:0] & mask;
   assign fidx     = free_ff[IW-1:0] & mask;
   assign cache_entry = cache_vld_ff[idx] ? cache_ff[idx] : AW'(idx);
   assign hit      = (cache_entry == prefix_ff);
   assign send     = cmd.add_entry || cmd.send_end;
   assign fresh    = cmd.add_entry && !full;
   assign send_val = hit ? 11'({idx, 1'b1}) : {prefix_ff, 1'b0};
   assign send_bits = hit ? 4'(blk_bits_ff) + 4'd1 : width_ff + 4'd1;
   assign grown    = fresh ? free_ff : free_ff - 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // memory ports
   always_ff @(posedge clock) begin
      char_q  <= node_char_mem[rd_addr];
      child_q <= node_child_mem[rd_addr];
      sib_q   <= node_sibling_mem[rd_addr];
      if (cmd.link_child && !full) begin
         node_child_mem[prefix_ff] <= free_ff[AW-1:0];
      end else if (fresh) begin
         node_child_mem[free_ff[AW-1:0]] <= '0;
      end
      if (cmd.link_sib && !full) begin
         node_sibling_mem[nd_ff] <= free_ff[AW-1:0];
      end else if (fresh) begin
         node_sibling_mem[free_ff[AW-1:0]] <= '0;
      end
      if (fresh) begin
         node_char_mem[free_ff[AW-1:0]] <= byte_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         byte_ff <= req_byte;
         end_ff  <= req_last;
      end
      if (cmd.walk_first) begin
         nd_ff <= first;
      end else if (cmd.walk_next) begin
         nd_ff <= sib_q;
      end
      if (cmd.start_blk || cmd.add_entry) begin
         prefix_ff <= {2'b00, byte_ff};
      end else if (cmd.take_match) begin
         prefix_ff <= nd_ff;
      end
      for (int i = 0; i < lzwmc_pkg::CACHE_N; i++) begin
         if (fresh && fidx == IW'(i)) begin
            cache_ff[i] <= free_ff[AW-1:0];
         end else if (send && !hit && idx == IW'(i)) begin
            cache_ff[i] <= prefix_ff;
         end
      end
      if (cmd.emit_hdr) begin
         rsp_byte_ff <= 8'(8'd1 << eff_bits);
         rsp_last_ff <= 1'b0;
      end else if (cmd.emit_acc) begin
         rsp_byte_ff <= acc_ff[7:0];
         rsp_last_ff <= cmd.emit_last && (cnt_ff == lzwmc_pkg::CNT_W'(8));
      end else if (cmd.emit_pad) begin
         rsp_byte_ff <= acc_ff[7:0];
         rsp_last_ff <= 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= lzwmc_pkg::CACHE_BITS_RST;
         blk_bits_ff  <= lzwmc_pkg::CACHE_BITS_RST;
         inside_ff    <= 1'b0;
         free_ff      <= lzwmc_pkg::FIRST_FREE;
         width_ff     <= lzwmc_pkg::WIDTH_RST;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         root_vld_ff  <= '0;
         cache_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            csr_ff <= csr_data;
         end
         if (cmd.start_blk) begin
            blk_bits_ff  <= eff_bits;
            inside_ff    <= 1'b1;
            free_ff      <= lzwmc_pkg::FIRST_FREE;
            width_ff     <= lzwmc_pkg::WIDTH_RST;
            acc_ff       <= '0;
            cnt_ff       <= '0;
            root_vld_ff  <= '0;
            cache_vld_ff <= '0;
         end else begin
            if (cmd.send_end) begin
               inside_ff <= 1'b0;
            end
            if (cmd.link_child && !full && prefix_ff[AW-1:8] == '0) begin
               root_vld_ff[prefix_ff[7:0]] <= 1'b1;
            end
            if (fresh) begin
               free_ff <= free_ff + 1'b1;
            end
            if (cmd.add_entry && (grown >> width_ff) != '0) begin
               width_ff <= width_ff + 4'd1;
            end
            if (send) begin
               acc_ff <= acc_ff | (lzwmc_pkg::ACC_W'(send_val) << cnt_ff);
               cnt_ff <= cnt_ff + lzwmc_pkg::CNT_W'(send_bits);
            end else if (cmd.emit_acc) begin
               acc_ff <= acc_ff >> 8;
               cnt_ff <= cnt_ff - lzwmc_pkg::CNT_W'(8);
            end else if (cmd.emit_pad) begin
               acc_ff <= '0;
               cnt_ff <= '0;
            end
            for (int i = 0; i < lzwmc_pkg::CACHE_N; i++) begin
               if ((fresh && fidx == IW'(i)) || (send && !hit && idx == IW'(i))) begin
                  cache_vld_ff[i] <= 1'b1;
               end
            end
         end
         if (cmd.emit_hdr || cmd.emit_acc || cmd.emit_pad) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.blk_open   = inside_ff;
   assign sts.blk_end    = end_ff;
   assign sts.first_zero = (first == '0);
   assign sts.match      = (nd_char == byte_ff);
   assign sts.sib_zero   = (sib_q == '0);
   assign sts.cnt_ge8    = (cnt_ff >= lzwmc_pkg::CNT_W'(8));
   assign sts.cnt_zero   = (cnt_ff == '0);
   assign sts.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: rtl/lzw_minicache_compressor.sv
// ----------------------------------------------------------------------------
// lzw_minicache_compressor
// per-block lzw compressor with a trie dictionary and a mini-cache of codes
// ----------------------------------------------------------------------------
// sequence: the first byte of a block emits the header byte; later bytes read the
//   child, compare trie nodes one by one, and a new entry also sends a code and its output bytes
// throughput: one byte in flight; a new byte is taken only when the sequencer is idle,
//   and the pace is set by the sibling-chain walk through the trie memories
// block end sends the end code, flushes the full bytes and pads any bits left over
// reset: synchronous, cache index bits 3, no block open; dictionary reinit per block
// ----------------------------------------------------------------------------
module lzw_minicache_compressor (
   input  logic       clock,
   input  logic       reset,
   // input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // block_end
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tlast,    // block_done
   // cache size register
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_data      // [2:0] cache_index_bits
);

   lzwmc_pkg::cmd_type cmd;
   lzwmc_pkg::sts_type sts;

   // register always takes the write transfer
   assign csr_ready = 1'b1;

   // sequencer
   lzwmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // memories, cache, bit packer, output register
   lzwmc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

   // packer never holds a full byte while waiting for input
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.cnt_ge8)
      else $error("full byte left in packer at idle");

   // the block is closed once its final byte is shown
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !sts.blk_open)
      else $error("block still open at final byte");

   // output register is only loaded when it has room
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_hdr || cmd.emit_acc || cmd.emit_pad) |-> sts.out_free)
      else $error("output byte overwritten");

endmodule
